/* src/sfcr_pkg.sv */
// Types and constants shared by the sync-framed coordinate receiver.
// No dependencies; the top level takes names from here by scope.
`timescale 1ns / 1ps

package sfcr_pkg;

  localparam int unsigned RX_W       = 8;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned NUM_COORDS = 6;
  localparam int unsigned DEC_BYTES  = 2 * NUM_COORDS;
  localparam int unsigned OUT_DATA_W = COORD_W * NUM_COORDS;
  localparam int unsigned SYNC_PAT_W = 40;
  localparam int unsigned CHK_W      = 16;
  localparam int unsigned SUM_LEN_W  = 4;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = SYNC_PAT_W;
  localparam int unsigned LEN_W      = 8;

  localparam logic [SYNC_PAT_W-1:0] SYNC_PAT_RST = 40'h41_42_43_44_C0;
  localparam logic [CHK_W-1:0]      CHK_RST      = 16'd63002;
  localparam logic [SUM_LEN_W-1:0]  SUM_LEN_RST  = 4'd11;

  // ((hi-1)<<8) + (lo-1) modulo 2^16 is {hi,lo} minus this
  localparam logic [COORD_W-1:0] COORD_BIAS = 16'h0101;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SYNC_PATTERN      = 2'd0,
    CFG_EXPECTED_CHECKSUM = 2'd1,
    CFG_SUM_LENGTH        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                                  checksum_ok;
    logic [NUM_COORDS-1:0][COORD_W-1:0]    coords;
  } result_t;

endpackage

/* src/sync_framed_coordinate_receiver_top.sv */
// Sync-framed coordinate receiver: byte/cycle in when ready, one result per packet.
// Depends on sfcr_pkg for widths, register indexes and the result type.
`timescale 1ns / 1ps

// Takes one received byte per clock on in_* whenever in_tready is high. Each
// byte is matched against the SYNC_BYTES sync pattern, the length byte and
// the payload entirely within the cycle it is accepted; the checksum over the
// store and the coordinate decode run in that same cycle on the last payload
// byte; the result is registered, into the skid stage if out_* is stalled. The
// output side holds two results (output register plus skid stage), so in_tready
// drops only when both are occupied. Sustained rate while in_tready is high: one
// byte per cycle. Configuration writes on cfg_* take effect on the next byte.
module sync_framed_coordinate_receiver_top #(
  parameter int unsigned STORE_BYTES = 12,
  parameter int unsigned SYNC_BYTES  = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sfcr_pkg::RX_W-1:0]           in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] coord_x1, [31:16] coord_y1, [47:32] coord_x2,
  // [63:48] coord_y2, [79:64] coord_x3, [95:80] coord_y3
  output logic [sfcr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser,  // [0] checksum_ok
  // configuration
  input  logic                                cfg_we,
  input  logic [sfcr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sfcr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned MP_W    = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;
  localparam int unsigned SUM_W   = 16 + $clog2(STORE_BYTES);
  localparam int unsigned CNT_W   = $clog2(STORE_BYTES + 1);
  localparam int unsigned LCW     = (CNT_W > sfcr_pkg::SUM_LEN_W) ? CNT_W
                                                                  : sfcr_pkg::SUM_LEN_W;
  localparam int unsigned PAD_BYTES = (STORE_BYTES > sfcr_pkg::DEC_BYTES) ? STORE_BYTES
                                                                         : sfcr_pkg::DEC_BYTES;
  localparam logic [LCW-1:0]                 STORE_LIM   = LCW'(STORE_BYTES);
  localparam logic [sfcr_pkg::LEN_W-1:0]     STORE_LIM_B = sfcr_pkg::LEN_W'(STORE_BYTES);
  localparam logic [MP_W-1:0]                MP_LAST     = MP_W'(SYNC_BYTES - 1);
  localparam logic [5:0]                     SH_TOP      = 6'((SYNC_BYTES - 1) * 8);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_PAYLOAD
  } phase_t;

  // configuration registers
  logic [sfcr_pkg::SYNC_PAT_W-1:0] sync_pat_r;
  logic [sfcr_pkg::CHK_W-1:0]      exp_chk_r;
  logic [sfcr_pkg::SUM_LEN_W-1:0]  sum_len_r;

  // receive state
  phase_t                                          phase_r, phase_nxt;
  logic [MP_W-1:0]                                 mp_r, mp_nxt;
  logic [sfcr_pkg::LEN_W-1:0]                      len_r, len_nxt;
  logic [sfcr_pkg::LEN_W-1:0]                      idx_r, idx_nxt;
  logic [STORE_BYTES-1:0][7:0]                     store_r, store_nxt;
  logic [sfcr_pkg::NUM_COORDS-1:0][sfcr_pkg::COORD_W-1:0] coord_r, coord_nxt;

  // output register and skid stage
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  sfcr_pkg::result_t   out_r, out_nxt;
  sfcr_pkg::result_t   skid_r, skid_nxt;

  logic                                   in_acc;
  logic                                   out_pop;
  logic                                   last_byte;
  logic                                   push;
  logic [63:0]                            sync_ext;
  logic [5:0]                             sync_sh;
  logic [7:0]                             sync_byte;
  logic [sfcr_pkg::LEN_W-1:0]             wr_lim;
  logic                                   wr_en;
  logic [LCW-1:0]                         sum_n;
  logic [SUM_W-1:0]                       sum;
  logic [16:0]                            fold1;
  logic [15:0]                            fold2;
  logic                                   chk_ok;
  logic [PAD_BYTES-1:0][7:0]              store_pad;
  logic [sfcr_pkg::NUM_COORDS-1:0][sfcr_pkg::COORD_W-1:0] dec_coord;
  sfcr_pkg::result_t                      res;

  assign in_tready  = !skid_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_pop    = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.coords;
  assign out_tuser  = out_r.checksum_ok;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pat_r <= sfcr_pkg::SYNC_PAT_RST;
      exp_chk_r  <= sfcr_pkg::CHK_RST;
      sum_len_r  <= sfcr_pkg::SUM_LEN_RST;
    end else if (cfg_we) begin
      unique case (sfcr_pkg::cfg_reg_t'(cfg_addr))
        sfcr_pkg::CFG_SYNC_PATTERN:      sync_pat_r <= cfg_wdata;
        sfcr_pkg::CFG_EXPECTED_CHECKSUM: exp_chk_r  <= cfg_wdata[sfcr_pkg::CHK_W-1:0];
        sfcr_pkg::CFG_SUM_LENGTH:        sum_len_r  <= cfg_wdata[sfcr_pkg::SUM_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sync byte, checksum and decode
  // ---------------------------------------------------------------------------
  // first sync byte sits in the top used octet; octets past the pattern read zero
  assign sync_ext  = {{(64 - sfcr_pkg::SYNC_PAT_W){1'b0}}, sync_pat_r};
  assign sync_sh   = SH_TOP - 6'({mp_r, 3'b000});
  assign sync_byte = 8'(sync_ext >> sync_sh);

  assign last_byte = (phase_r == PH_PAYLOAD) && (idx_r == len_r);
  assign push      = in_acc && last_byte;

  assign wr_lim = (len_r == '0) ? '0 : len_r - 1'b1;
  assign wr_en  = (phase_r == PH_PAYLOAD) && (idx_r < wr_lim) && (idx_r < STORE_LIM_B);

  // saturate the covered length to the store size
  assign sum_n = (LCW'(sum_len_r) > STORE_LIM) ? STORE_LIM : LCW'(sum_len_r);

  // plain multi-operand sum of masked terms, so it maps onto an adder tree
  always_comb begin
    sum = '0;
    for (int k = 0; k < STORE_BYTES; k++) begin
      // even bytes are the high half of a big-endian word; uncovered bytes add zero
      sum = sum + ((k[0] ? SUM_W'({8'h00, store_r[k]}) : SUM_W'({store_r[k], 8'h00}))
                   & {SUM_W{(LCW'(k) < sum_n)}});
    end
  end

  // two end-around folds cover any carry the tree can produce
  assign fold1  = 17'(sum[15:0]) + 17'(sum[SUM_W-1:16]);
  assign fold2  = fold1[15:0] + 16'(fold1[16]);
  assign chk_ok = (~fold2 == exp_chk_r);

  for (genvar g = 0; g < PAD_BYTES; g++) begin : g_pad
    if (g < STORE_BYTES) begin : g_used
      assign store_pad[g] = store_r[g];
    end else begin : g_zero
      assign store_pad[g] = 8'h00;
    end
  end

  always_comb begin
    for (int j = 0; j < sfcr_pkg::NUM_COORDS; j++) begin
      dec_coord[j] = {store_pad[2*j], store_pad[2*j+1]} - sfcr_pkg::COORD_BIAS;
    end
  end

  assign res.checksum_ok = chk_ok;
  assign res.coords      = chk_ok ? dec_coord : coord_r;

  // ---------------------------------------------------------------------------
  // Receive state
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    mp_nxt    = mp_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    store_nxt = store_r;
    coord_nxt = coord_r;
    if (in_acc) begin
      unique case (phase_r)
        PH_LEN: begin
          len_nxt   = in_tdata;
          idx_nxt   = '0;
          phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          for (int k = 0; k < STORE_BYTES; k++) begin
            if (wr_en && (idx_r == sfcr_pkg::LEN_W'(k))) store_nxt[k] = in_tdata;
          end
          if (last_byte) begin
            coord_nxt = res.coords;
            phase_nxt = PH_HUNT;
            mp_nxt    = '0;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        default: begin
          // hunt: a mismatching byte drops the match without being retried
          phase_nxt = PH_HUNT;
          if (in_tdata == sync_byte) begin
            if (mp_r == MP_LAST) begin
              mp_nxt    = '0;
              phase_nxt = PH_LEN;
            end else begin
              mp_nxt = mp_r + 1'b1;
            end
          end else begin
            mp_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      mp_r    <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      store_r <= '0;
      coord_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      mp_r    <= mp_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      store_r <= store_nxt;
      coord_r <= coord_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid stage
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_pop || !out_valid_r) begin
      if (skid_valid_r) begin
        // advance the skid entry; a new result cannot arrive while it is full
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      // hold the stalled result, park the new one
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("last payload byte did not produce a result");

  a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mp_r <= MP_LAST)
    else $error("sync match position beyond pattern length");

  a_match_clear_out_of_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HUNT) |-> (mp_r == '0))
    else $error("sync match position kept outside hunting");

  a_len_to_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (phase_r == PH_LEN)) |=> ((phase_r == PH_PAYLOAD) && (idx_r == '0)))
    else $error("length byte did not start the payload");
`endif

endmodule
